// ===== src/softened_gravity_acceleration_defines.svh =====
// Assertion macros shared by the front, square-root and divider modules
`ifndef SOFTENED_GRAVITY_ACCELERATION_DEFINES_SVH
`define SOFTENED_GRAVITY_ACCELERATION_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is held
`define SGA_ASSERT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while reset is held
`define SGA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define SGA_ASSERT(lbl, clk, rstn, ante, cons, msg)
`define SGA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== src/sga_pkg.sv =====
`default_nettype none
package sga_pkg;

  localparam int WORD_W   = 32;
  localparam int NUM_AXES = 3;
  // sum of squares, units 2^-32
  localparam int S_W = 66;
  // radicand S * 2^32
  localparam int V_W = S_W + 32;
  // root of the radicand
  localparam int M_W = 49;
  // numerator product G*m*|r|, units 2^-48
  localparam int P_W = 96;
  // denominator S * M, units 2^-64
  localparam int D_W = 115;
  // divider partial remainder
  localparam int R_W = D_W + 1;
  // quotient bits produced by the divider
  localparam int Q_W = 32;

  localparam logic [0:0] CFG_GRAV_CONST = 1'b0;
  localparam logic [0:0] CFG_SOFTENING  = 1'b1;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_SAT  = 2'd1;
  localparam logic [1:0] STATUS_ZERO = 2'd2;

  localparam logic [WORD_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] NEG_LIMIT = 32'h8000_0000;

  localparam logic [WORD_W-1:0] GRAV_CONST_RESET = 32'h0001_0000;
  localparam logic [WORD_W-1:0] SOFTENING_RESET  = 32'h0000_0000;

  typedef struct packed {
    logic        [WORD_W-1:0] source_mass;
    logic signed [WORD_W-1:0] disp_x;
    logic signed [WORD_W-1:0] disp_y;
    logic signed [WORD_W-1:0] disp_z;
  } sga_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] accel_x;
    logic signed [WORD_W-1:0] accel_y;
    logic signed [WORD_W-1:0] accel_z;
    logic        [1:0]        status;
  } sga_out_t;

  // front end result: sum of squares and per-axis numerators
  typedef struct packed {
    logic [S_W-1:0]               s;
    logic [NUM_AXES-1:0][P_W-1:0] p;
    logic [NUM_AXES-1:0]          neg;
    logic                         zero;
  } sga_front_t;

  typedef struct packed {
    sga_front_t     side;
    logic [M_W-1:0] m;
  } sga_root_t;

  // divider input: denominator and numerators
  typedef struct packed {
    logic [D_W-1:0]               d;
    logic [NUM_AXES-1:0][P_W-1:0] p;
    logic [NUM_AXES-1:0]          neg;
    logic                         zero;
  } sga_quot_t;

endpackage
`default_nettype wire

// ===== src/sga_front.sv =====
`default_nettype none
`include "softened_gravity_acceleration_defines.svh"
module sga_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sga_pkg::WORD_W-1:0]    grav_const_i,
  input  logic [sga_pkg::WORD_W-1:0]    softening_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sga_pkg::sga_in_t              in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sga_pkg::sga_front_t           out_word_o
);
  import sga_pkg::*;

  typedef struct packed {
    logic [NUM_AXES-1:0][WORD_W-1:0]   mag;
    logic [NUM_AXES-1:0]               neg;
    logic [NUM_AXES-1:0][2*WORD_W-1:0] sq;
    logic [2*WORD_W-1:0]               eps_sq;
    logic [2*WORD_W-1:0]               gm;
  } stage_a_t;

  typedef struct packed {
    logic [S_W-1:0]                    s;
    logic [NUM_AXES-1:0][2*WORD_W-1:0] p_lo;
    logic [NUM_AXES-1:0][2*WORD_W-1:0] p_hi;
    logic [NUM_AXES-1:0]               neg;
  } stage_b_t;

  stage_a_t   a_d, a_q;
  stage_b_t   b_d, b_q;
  sga_front_t c_d, c_q;
  logic       a_vld_q, b_vld_q, c_vld_q;
  logic       en_a, en_b, en_c;
  logic [NUM_AXES-1:0][WORD_W-1:0] disp;

  // advance a stage when it is empty or its word moves on
  assign en_c       = !c_vld_q || out_ready_i;
  assign en_b       = !b_vld_q || en_c;
  assign en_a       = !a_vld_q || en_b;
  assign in_ready_o = en_a;

  assign disp[0] = in_word_i.disp_x;
  assign disp[1] = in_word_i.disp_y;
  assign disp[2] = in_word_i.disp_z;

  // magnitudes, squares, softening square and G*m
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      a_d.neg[k] = disp[k][WORD_W-1];
      a_d.mag[k] = a_d.neg[k] ? (~disp[k] + 32'd1) : disp[k];
      a_d.sq[k]  = {32'd0, a_d.mag[k]} * {32'd0, a_d.mag[k]};
    end
    a_d.eps_sq = {32'd0, softening_i} * {32'd0, softening_i};
    a_d.gm     = {32'd0, grav_const_i} * {32'd0, in_word_i.source_mass};
  end

  // sum of squares and split numerator products
  always_comb begin
    b_d.s = S_W'(a_q.sq[0]) + S_W'(a_q.sq[1]) + S_W'(a_q.sq[2]) + S_W'(a_q.eps_sq);
    for (int k = 0; k < NUM_AXES; k++) begin
      b_d.p_lo[k] = {32'd0, a_q.gm[WORD_W-1:0]} * {32'd0, a_q.mag[k]};
      b_d.p_hi[k] = {32'd0, a_q.gm[2*WORD_W-1:WORD_W]} * {32'd0, a_q.mag[k]};
    end
    b_d.neg = a_q.neg;
  end

  // join the numerator halves, flag a zero denominator
  always_comb begin
    c_d.s = b_q.s;
    for (int k = 0; k < NUM_AXES; k++) begin
      c_d.p[k] = P_W'(b_q.p_lo[k]) + {b_q.p_hi[k], 32'd0};
    end
    c_d.neg  = b_q.neg;
    c_d.zero = (b_q.s == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      if (en_a) a_vld_q <= in_valid_i;
      if (en_b) b_vld_q <= a_vld_q;
      if (en_c) c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) a_q <= a_d;
    if (en_b) b_q <= b_d;
    if (en_c) c_q <= c_d;
  end

  assign out_valid_o = c_vld_q;
  assign out_word_o  = c_q;

  `SGA_ASSERT_NXT(a_zero_flag, clk_i, rst_ni, b_vld_q && en_c && (b_q.s == '0), c_vld_q && c_q.zero, "zero sum lost its flag")

endmodule
`default_nettype wire

// ===== src/sga_isqrt.sv =====
`default_nettype none
`include "softened_gravity_acceleration_defines.svh"
module sga_isqrt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sga_pkg::sga_front_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sga_pkg::sga_root_t   out_word_o
);
  import sga_pkg::*;

  localparam int RemW = V_W + 2;

  typedef struct packed {
    sga_front_t      side;
    logic [RemW-1:0] rem;
    logic [M_W-1:0]  root;
  } sq_stage_t;

  sq_stage_t       stage_in [M_W];
  sq_stage_t       stage_q  [M_W];
  logic [M_W-1:0]  vld_in;
  logic [M_W-1:0]  valid_q;
  logic [M_W-1:0]  en;
  logic [RemW-1:0] twice_root;

  // one root bit per stage, most significant first
  for (genvar k = 0; k < M_W; k++) begin : g_bit
    localparam int Bit = M_W - 1 - k;
    logic [RemW-1:0] trial;
    logic            take;
    sq_stage_t       stage_d;
    sq_stage_t       stg_q;
    logic            vld_q;

    if (k == 0) begin : g_first
      assign stage_in[k] = '{side: in_word_i,
                             rem:  {{(RemW-V_W){1'b0}}, in_word_i.s, {(V_W-S_W){1'b0}}},
                             root: '0};
      assign vld_in[k]   = in_valid_i;
    end else begin : g_next
      assign stage_in[k] = stage_q[k-1];
      assign vld_in[k]   = valid_q[k-1];
    end

    if (k == M_W - 1) begin : g_last_en
      assign en[k] = !valid_q[k] || out_ready_i;
    end else begin : g_mid_en
      assign en[k] = !valid_q[k] || en[k+1];
    end

    // try setting this bit: (q + 2^b)^2 - q^2 = q*2^(b+1) + 2^(2b)
    always_comb begin
      trial = ({{(RemW-M_W){1'b0}}, stage_in[k].root} << (Bit + 1))
            | ({{(RemW-1){1'b0}}, 1'b1} << (2 * Bit));
      take  = (stage_in[k].rem >= trial);
      stage_d      = stage_in[k];
      stage_d.rem  = take ? (stage_in[k].rem - trial) : stage_in[k].rem;
      stage_d.root = stage_in[k].root | ({{(M_W-1){1'b0}}, take} << Bit);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en[k]) begin
        vld_q <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) stg_q <= stage_d;
    end

    assign valid_q[k] = vld_q;
    assign stage_q[k] = stg_q;
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[M_W-1];
  assign out_word_o  = '{side: stage_q[M_W-1].side, m: stage_q[M_W-1].root};

  // floor root leaves a remainder no larger than twice the root
  assign twice_root = {{(RemW-M_W-1){1'b0}}, stage_q[M_W-1].root, 1'b0};

  `SGA_ASSERT(a_root_floor, clk_i, rst_ni, out_valid_o, stage_q[M_W-1].rem <= twice_root, "root is not the floor root")

endmodule
`default_nettype wire

// ===== src/sga_denom.sv =====
`default_nettype none
module sga_denom (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sga_pkg::sga_root_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sga_pkg::sga_quot_t  out_word_o
);
  import sga_pkg::*;

  localparam int SHi = S_W - 32;
  localparam int MHi = M_W - 32;

  typedef struct packed {
    logic [NUM_AXES-1:0][P_W-1:0] p;
    logic [NUM_AXES-1:0]          neg;
    logic                         zero;
    logic [63:0]                  pp00;
    logic [32+MHi-1:0]            pp01;
    logic [SHi+32-1:0]            pp10;
    logic [SHi+MHi-1:0]           pp11;
  } dn_stage_t;

  dn_stage_t a_d, a_q;
  sga_quot_t b_d, b_q;
  logic      a_vld_q, b_vld_q;
  logic      en_a, en_b;

  assign en_b       = !b_vld_q || out_ready_i;
  assign en_a       = !a_vld_q || en_b;
  assign in_ready_o = en_a;

  // partial products of S * M
  always_comb begin
    a_d.p    = in_word_i.side.p;
    a_d.neg  = in_word_i.side.neg;
    a_d.zero = in_word_i.side.zero;
    a_d.pp00 = {32'd0, in_word_i.side.s[31:0]} * {32'd0, in_word_i.m[31:0]};
    a_d.pp01 = (32+MHi)'(in_word_i.side.s[31:0]) * (32+MHi)'(in_word_i.m[M_W-1:32]);
    a_d.pp10 = (SHi+32)'(in_word_i.side.s[S_W-1:32]) * (SHi+32)'(in_word_i.m[31:0]);
    a_d.pp11 = (SHi+MHi)'(in_word_i.side.s[S_W-1:32]) * (SHi+MHi)'(in_word_i.m[M_W-1:32]);
  end

  // sum the partial products into the denominator
  always_comb begin
    b_d.p    = a_q.p;
    b_d.neg  = a_q.neg;
    b_d.zero = a_q.zero;
    b_d.d    = D_W'(a_q.pp00)
             + (D_W'(a_q.pp01) << 32)
             + (D_W'(a_q.pp10) << 32)
             + (D_W'(a_q.pp11) << 64);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (en_a) a_vld_q <= in_valid_i;
      if (en_b) b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) a_q <= a_d;
    if (en_b) b_q <= b_d;
  end

  assign out_valid_o = b_vld_q;
  assign out_word_o  = b_q;

endmodule
`default_nettype wire

// ===== src/sga_divide.sv =====
`default_nettype none
`include "softened_gravity_acceleration_defines.svh"
module sga_divide (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sga_pkg::sga_quot_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sga_pkg::sga_out_t   out_word_o
);
  import sga_pkg::*;

  typedef struct packed {
    logic [NUM_AXES-1:0][R_W-1:0] rem;
    logic [NUM_AXES-1:0][Q_W-1:0] quo;
    logic [NUM_AXES-1:0]          ovf;
    logic [D_W-1:0]               d;
    logic [NUM_AXES-1:0]          neg;
    logic                         zero;
  } dv_stage_t;

  dv_stage_t       stage_q [Q_W+1];
  dv_stage_t       first_d;
  logic [Q_W+1:0]  valid_q;
  logic [Q_W+1:0]  en;
  sga_out_t        out_d, out_q;
  logic            first_vld_q, out_vld_q;
  dv_stage_t       first_q;

  // overflow check: a quotient of 2^32 or more saturates on any axis
  always_comb begin
    first_d.d    = in_word_i.d;
    first_d.neg  = in_word_i.neg;
    first_d.zero = in_word_i.zero;
    for (int k = 0; k < NUM_AXES; k++) begin
      first_d.ovf[k] = ({{(D_W-P_W){1'b0}}, in_word_i.p[k]} >= in_word_i.d);
      first_d.rem[k] = R_W'(in_word_i.p[k]);
      first_d.quo[k] = '0;
    end
  end

  assign en[0] = !valid_q[0] || en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_vld_q <= 1'b0;
    end else if (en[0]) begin
      first_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) first_q <= first_d;
  end

  assign valid_q[0] = first_vld_q;
  assign stage_q[0] = first_q;

  // one quotient bit per stage, all three axes side by side
  for (genvar j = 1; j <= Q_W; j++) begin : g_step
    dv_stage_t stage_d;
    dv_stage_t stg_q;
    logic      vld_q;

    assign en[j] = !valid_q[j] || en[j+1];

    always_comb begin
      logic [R_W-1:0] shifted;
      logic           take;
      stage_d = stage_q[j-1];
      for (int k = 0; k < NUM_AXES; k++) begin
        shifted = {stage_q[j-1].rem[k][R_W-2:0], 1'b0};
        take    = (shifted >= {1'b0, stage_q[j-1].d});
        stage_d.rem[k] = take ? (shifted - {1'b0, stage_q[j-1].d}) : shifted;
        stage_d.quo[k] = {stage_q[j-1].quo[k][Q_W-2:0], take};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en[j]) begin
        vld_q <= valid_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[j]) stg_q <= stage_d;
    end

    assign valid_q[j] = vld_q;
    assign stage_q[j] = stg_q;
  end

  // saturate, restore the sign, pick the status
  always_comb begin
    logic [NUM_AXES-1:0][WORD_W-1:0] acc;
    logic [WORD_W-1:0]               limit;
    logic [WORD_W-1:0]               mag;
    logic                            sat_any;
    logic                            sat_k;
    sat_any = 1'b0;
    for (int k = 0; k < NUM_AXES; k++) begin
      limit   = stage_q[Q_W].neg[k] ? NEG_LIMIT : POS_LIMIT;
      sat_k   = stage_q[Q_W].ovf[k] || (stage_q[Q_W].quo[k] > limit);
      mag     = sat_k ? limit : stage_q[Q_W].quo[k];
      acc[k]  = stage_q[Q_W].neg[k] ? (32'd0 - mag) : mag;
      sat_any = sat_any | sat_k;
    end
    if (stage_q[Q_W].zero) begin
      out_d.accel_x = '0;
      out_d.accel_y = '0;
      out_d.accel_z = '0;
      out_d.status  = STATUS_ZERO;
    end else begin
      out_d.accel_x = acc[0];
      out_d.accel_y = acc[1];
      out_d.accel_z = acc[2];
      out_d.status  = sat_any ? STATUS_SAT : STATUS_OK;
    end
  end

  assign en[Q_W+1] = !valid_q[Q_W+1] || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en[Q_W+1]) begin
      out_vld_q <= valid_q[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[Q_W+1]) out_q <= out_d;
  end

  assign valid_q[Q_W+1] = out_vld_q;
  assign in_ready_o     = en[0];
  assign out_valid_o    = out_vld_q;
  assign out_word_o     = out_q;

  `SGA_ASSERT(a_zero_out, clk_i, rst_ni, out_vld_q && (out_q.status == STATUS_ZERO), (out_q.accel_x == '0) && (out_q.accel_y == '0) && (out_q.accel_z == '0), "zero denominator gave nonzero output")
  `SGA_ASSERT(a_sat_limit, clk_i, rst_ni, out_vld_q && (out_q.status == STATUS_SAT), (out_q.accel_x == POS_LIMIT) || (out_q.accel_x == NEG_LIMIT) || (out_q.accel_y == POS_LIMIT) || (out_q.accel_y == NEG_LIMIT) || (out_q.accel_z == POS_LIMIT) || (out_q.accel_z == NEG_LIMIT), "saturation flagged with no axis at a limit")

endmodule
`default_nettype wire

// ===== src/softened_gravity_acceleration.sv =====
// Softened gravity kernel: for each input word (source mass and displacement, Q16.16) it
// returns G*m*r / (|r|^2 + eps^2)^1.5 per axis in signed Q16.16, truncated toward zero,
// saturated with status 1 on overflow, and zero with status 2 when the denominator is zero.
// The pipeline takes one word every cycle while out_stall_i is low and holds up to 88 words.
// Its length is set by the square root, which settles one of its 49 root bits per stage, and
// by the divider, which settles one of 32 quotient bits per stage after an overflow check;
// three front stages form the squares and products, two the denominator, and one saturates
// and signs the result. Empty stages close up behind a stalled output, so input is taken
// while a result waits. Write grav_const and softening only while no word is in flight.
`default_nettype none
module softened_gravity_acceleration (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [sga_pkg::WORD_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  sga_pkg::sga_in_t            in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output sga_pkg::sga_out_t           out_word_o
);
  import sga_pkg::*;

  logic [WORD_W-1:0] grav_const_q;
  logic [WORD_W-1:0] softening_q;
  logic              front_ready, front_valid;
  logic              root_ready, root_valid;
  logic              denom_ready, denom_valid;
  logic              div_ready;
  sga_front_t        front_word;
  sga_root_t         root_word;
  sga_quot_t         denom_word;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_const_q <= GRAV_CONST_RESET;
      softening_q  <= SOFTENING_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRAV_CONST: grav_const_q <= cfg_data_i;
        CFG_SOFTENING:  softening_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sga_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .grav_const_i (grav_const_q),
    .softening_i  (softening_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (front_ready),
    .in_word_i    (in_word_i),
    .out_valid_o  (front_valid),
    .out_ready_i  (root_ready),
    .out_word_o   (front_word)
  );

  sga_isqrt u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (root_ready),
    .in_word_i   (front_word),
    .out_valid_o (root_valid),
    .out_ready_i (denom_ready),
    .out_word_o  (root_word)
  );

  sga_denom u_denom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (root_valid),
    .in_ready_o  (denom_ready),
    .in_word_i   (root_word),
    .out_valid_o (denom_valid),
    .out_ready_i (div_ready),
    .out_word_o  (denom_word)
  );

  sga_divide u_divide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (denom_valid),
    .in_ready_o  (div_ready),
    .in_word_i   (denom_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .out_word_o  (out_word_o)
  );

  assign in_stall_o = !front_ready;

endmodule
`default_nettype wire
